@@ rtl/bsis_pkg.sv @@
package bsis_pkg;

  // Fixed field widths.
  localparam int unsigned LW   = 5;   // log_size field
  localparam int unsigned STW  = 7;   // step_length field
  localparam int unsigned CHW  = 24;  // chunk_index field
  localparam int unsigned PW   = 31;  // sequence position, CHW + STW
  localparam int unsigned TW   = 32;  // sequence length
  localparam int unsigned IDXW = 16;  // element_index field
  localparam int unsigned PC_W = 4;

  // Register index, taken from paddr[2].
  localparam logic REG_LOG_SIZE    = 1'b0;
  localparam logic REG_STEP_LENGTH = 1'b1;

  typedef logic [PC_W-1:0] pc_t;

  // Program addresses.
  localparam pc_t PC_IDLE       = 4'd0;
  localparam pc_t PC_MUL        = 4'd1;
  localparam pc_t PC_CHECK      = 4'd2;
  localparam pc_t PC_SEEK_INIT  = 4'd3;
  localparam pc_t PC_SORT       = 4'd4;
  localparam pc_t PC_MERGE_INIT = 4'd5;
  localparam pc_t PC_MERGE_A    = 4'd6;
  localparam pc_t PC_MERGE_B    = 4'd7;
  localparam pc_t PC_FINISH     = 4'd8;
  localparam pc_t PC_EMIT       = 4'd9;
  localparam pc_t PC_END        = 4'd10;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_MUL,
    OP_SEEK_INIT,
    OP_SORT_STEP,
    OP_MERGE_INIT,
    OP_MERGE_A,
    OP_MERGE_B,
    OP_SEEK_END,
    OP_EMIT,
    OP_END
  } dp_op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_SKIP_SEEK,
    C_SORT_MORE,
    C_MERGE_DONE,
    C_EMIT_MORE
  } jump_cond_e;

  typedef struct packed {
    dp_op_e     op;
    jump_cond_e cond;
    pc_t        target;
  } uword_t;

  typedef struct packed {
    logic skip_seek;
    logic sort_more;
    logic merge_done;
    logic last;
  } dp_status_t;

  // Number of sequence positions of a full sort over 2^s slots: 2^s * s * (s+1) / 2.
  function automatic logic [TW-1:0] sort_len_f(input logic [LW-1:0] s);
    logic [TW-1:0] len;
    unique case (s)
      5'd0:    len = 32'd0;
      5'd1:    len = 32'd2;
      5'd2:    len = 32'd12;
      5'd3:    len = 32'd48;
      5'd4:    len = 32'd160;
      5'd5:    len = 32'd480;
      5'd6:    len = 32'd1344;
      5'd7:    len = 32'd3584;
      5'd8:    len = 32'd9216;
      5'd9:    len = 32'd23040;
      5'd10:   len = 32'd56320;
      5'd11:   len = 32'd135168;
      5'd12:   len = 32'd319488;
      5'd13:   len = 32'd745472;
      5'd14:   len = 32'd1720320;
      5'd15:   len = 32'd3932160;
      5'd16:   len = 32'd8912896;
      5'd17:   len = 32'd20054016;
      5'd18:   len = 32'd44826624;
      5'd19:   len = 32'd99614720;
      5'd20:   len = 32'd220200960;
      default: len = 32'd0;
    endcase
    return len;
  endfunction

  // Control store. A word jumps to its target when its condition holds,
  // otherwise it falls through to the next address.
  function automatic uword_t ucode_rom(input pc_t pc);
    uword_t w;
    unique case (pc)
      PC_IDLE:       w = '{op: OP_CAPTURE,    cond: C_NO_ITEM,    target: PC_IDLE};
      PC_MUL:        w = '{op: OP_MUL,        cond: C_NEVER,      target: PC_IDLE};
      PC_CHECK:      w = '{op: OP_NOP,        cond: C_SKIP_SEEK,  target: PC_EMIT};
      PC_SEEK_INIT:  w = '{op: OP_SEEK_INIT,  cond: C_NEVER,      target: PC_IDLE};
      PC_SORT:       w = '{op: OP_SORT_STEP,  cond: C_SORT_MORE,  target: PC_SORT};
      PC_MERGE_INIT: w = '{op: OP_MERGE_INIT, cond: C_NEVER,      target: PC_IDLE};
      PC_MERGE_A:    w = '{op: OP_MERGE_A,    cond: C_MERGE_DONE, target: PC_FINISH};
      PC_MERGE_B:    w = '{op: OP_MERGE_B,    cond: C_ALWAYS,     target: PC_MERGE_A};
      PC_FINISH:     w = '{op: OP_SEEK_END,   cond: C_NEVER,      target: PC_IDLE};
      PC_EMIT:       w = '{op: OP_EMIT,       cond: C_EMIT_MORE,  target: PC_EMIT};
      PC_END:        w = '{op: OP_END,        cond: C_ALWAYS,     target: PC_IDLE};
      default:       w = '{op: OP_NOP,        cond: C_ALWAYS,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/bsis_sequencer.sv @@
module bsis_sequencer
  import bsis_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output uword_t     uword_o
);

  pc_t    pc_q, pc_d;
  uword_t uword;
  logic   take;

  assign uword   = ucode_rom(pc_q);
  assign uword_o = uword;

  always_comb begin
    unique case (uword.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_ITEM:    take = !in_valid_i;
      C_SKIP_SEEK:  take = status_i.skip_seek;
      C_SORT_MORE:  take = status_i.sort_more;
      C_MERGE_DONE: take = status_i.merge_done;
      C_EMIT_MORE:  take = out_stall_i || !status_i.last;
      default:      take = 1'b1;
    endcase
    pc_d = take ? uword.target : pc_t'(pc_q + 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  a_last_item_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_EMIT && !out_stall_i && status_i.last) |=> (pc_q == PC_END))
    else $error("sequencer did not leave the emit loop after the last item");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_IDLE && in_valid_i) |=> (pc_q == PC_MUL))
    else $error("accepted item did not start the program");

endmodule

@@ rtl/bsis_datapath.sv @@
module bsis_datapath
  import bsis_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = 16,
  parameter int unsigned MAX_STEP     = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  uword_t                            uword_i,
  input  logic                              out_stall_i,
  input  logic                              resume_clr_i,
  input  logic [LW-1:0]                     n_i,
  input  logic [$clog2(MAX_STEP+1)-1:0]     step_i,
  input  logic [CHW-1:0]                    chunk_index_i,
  output dp_status_t                        status_o,
  output logic [IDXW-1:0]                   element_index_o,
  output logic                              past_end_o,
  output logic                              last_o
);

  localparam int unsigned AW = MAX_LOG_SIZE;
  localparam int unsigned BW = AW + 1;
  localparam int unsigned SW = $clog2(MAX_STEP + 1);
  localparam logic [BW-1:0] ONE_B = BW'(1);

  // Payload registers.
  logic [CHW-1:0] chunk_q, chunk_d;
  logic [PW-1:0]  pos_q, pos_d;
  logic [TW-1:0]  total_q, total_d;
  logic [PW-1:0]  p_q, p_d;

  // Walk state and control.
  logic [LW-1:0]  s_q, s_d;
  logic [LW-1:0]  m_q, m_d;
  logic [BW-1:0]  b_q, b_d;
  logic [AW-1:0]  j_q, j_d;
  logic           flip_q, flip_d;
  logic           sec_q, sec_d;
  logic [SW-1:0]  k_q, k_d;
  logic [PW-1:0]  resume_q, resume_d;
  logic           resume_valid_q, resume_valid_d;

  logic [PW-1:0]  prod;
  logic [PW+1:0]  sub, sub2, p_ext;
  logic           lt_sub, lt_sub2;
  logic [PW-1:0]  span_p, half_p;
  logic [BW-1:0]  bit_s1, bit_m1;
  logic           in_range;
  logic           merge_done;

  logic [AW:0]    stage_cnt;
  logic           stage_end;
  logic [BW-1:0]  pw_s, mask_s, low_s, low2_s, base_s;
  logic           merge_end, upper_half;
  logic [LW-1:0]  ctz;

  logic [BW-1:0]  span_b, idx;

  assign prod    = PW'(chunk_q) * PW'(step_i);

  assign sub     = (PW+2)'(sort_len_f(LW'(s_q - 1'b1)));
  assign sub2    = sub << 1;
  assign p_ext   = (PW+2)'(p_q);
  assign lt_sub  = p_ext < sub;
  assign lt_sub2 = p_ext < sub2;
  assign bit_s1  = ONE_B << LW'(s_q - 1'b1);

  assign span_p     = PW'(1) << m_q;
  assign half_p     = PW'(LW'(m_q - 1'b1)) << LW'(m_q - 1'b1);
  assign bit_m1     = ONE_B << LW'(m_q - 1'b1);
  assign merge_done = (m_q <= LW'(1)) || (p_q < span_p);

  assign in_range = TW'(pos_q) < total_q;

  // Next-comparator arithmetic of the depth-first walk.
  assign stage_cnt  = (AW+1)'(1) << LW'(m_q - 1'b1);
  assign stage_end  = ((AW+1)'(j_q) + 1'b1) == stage_cnt;
  assign pw_s       = ONE_B << s_q;
  assign mask_s     = pw_s - ONE_B;
  assign low_s      = b_q & mask_s;
  assign low2_s     = low_s + BW'(2);
  assign base_s     = b_q & ~mask_s;
  assign merge_end  = low2_s == pw_s;
  assign upper_half = |(b_q & pw_s);

  // The next half-cleaner is the right child whose offset has its lowest set bit at its level.
  always_comb begin
    ctz = '0;
    for (int i = BW - 1; i >= 0; i--) begin
      if (low2_s[i]) begin
        ctz = LW'(i);
      end
    end
  end

  assign span_b = ONE_B << m_q;
  always_comb begin
    if (!sec_q) begin
      idx = b_q + BW'(j_q);
    end else if (flip_q) begin
      idx = b_q + span_b - ONE_B - BW'(j_q);
    end else begin
      idx = b_q + BW'(j_q) + (span_b >> 1);
    end
  end

  assign element_index_o = in_range ? IDXW'(idx) : '0;
  assign past_end_o      = !in_range;
  assign last_o          = k_q == SW'(step_i - 1'b1);

  assign status_o.skip_seek  = (resume_valid_q && (pos_q == resume_q)) || !in_range;
  assign status_o.sort_more  = (s_q > LW'(1)) && lt_sub2;
  assign status_o.merge_done = merge_done;
  assign status_o.last       = last_o;

  always_comb begin
    chunk_d        = chunk_q;
    pos_d          = pos_q;
    total_d        = total_q;
    p_d            = p_q;
    s_d            = s_q;
    m_d            = m_q;
    b_d            = b_q;
    j_d            = j_q;
    flip_d         = flip_q;
    sec_d          = sec_q;
    k_d            = k_q;
    resume_d       = resume_q;
    resume_valid_d = resume_valid_q;

    unique case (uword_i.op)
      OP_CAPTURE: begin
        chunk_d = chunk_index_i;
      end
      OP_MUL: begin
        pos_d   = prod;
        total_d = sort_len_f(n_i);
        k_d     = '0;
      end
      OP_SEEK_INIT: begin
        p_d = pos_q;
        s_d = n_i;
        b_d = '0;
      end
      OP_SORT_STEP: begin
        if (s_q > LW'(1)) begin
          if (lt_sub) begin
            s_d = LW'(s_q - 1'b1);
          end else if (lt_sub2) begin
            p_d = p_q - PW'(sub);
            b_d = b_q + bit_s1;
            s_d = LW'(s_q - 1'b1);
          end else begin
            p_d = p_q - PW'(sub2);
          end
        end
      end
      OP_MERGE_INIT: begin
        m_d    = s_q;
        flip_d = 1'b1;
      end
      OP_MERGE_A: begin
        if (!merge_done) begin
          p_d = p_q - span_p;
        end
      end
      OP_MERGE_B: begin
        if (p_q >= half_p) begin
          p_d = p_q - half_p;
          b_d = b_q + bit_m1;
        end
        m_d    = LW'(m_q - 1'b1);
        flip_d = 1'b0;
      end
      OP_SEEK_END: begin
        j_d   = p_q[AW:1];
        sec_d = p_q[0];
      end
      OP_EMIT: begin
        if (!out_stall_i) begin
          k_d   = SW'(k_q + 1'b1);
          pos_d = PW'(pos_q + 1'b1);
          if (in_range) begin
            if (!sec_q) begin
              sec_d = 1'b1;
            end else begin
              sec_d = 1'b0;
              if (!stage_end) begin
                j_d = AW'(j_q + 1'b1);
              end else begin
                j_d = '0;
                if (m_q > LW'(1)) begin
                  m_d    = LW'(m_q - 1'b1);
                  flip_d = 1'b0;
                end else if (merge_end) begin
                  // The sort of this block is complete: go on to its sibling
                  // sort, or to the flip stage of the parent merge.
                  flip_d = 1'b1;
                  if (!upper_half) begin
                    s_d = LW'(1);
                    m_d = LW'(1);
                    b_d = base_s + pw_s;
                  end else begin
                    s_d = LW'(s_q + 1'b1);
                    m_d = LW'(s_q + 1'b1);
                    b_d = base_s - pw_s;
                  end
                end else begin
                  m_d    = ctz;
                  b_d    = base_s + low2_s;
                  flip_d = 1'b0;
                end
              end
            end
          end
        end
      end
      OP_END: begin
        resume_d       = pos_q;
        resume_valid_d = 1'b1;
      end
      default: begin
      end
    endcase

    if (resume_clr_i) begin
      resume_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    chunk_q <= chunk_d;
    pos_q   <= pos_d;
    total_q <= total_d;
    p_q     <= p_d;
  end

  // Reset leaves the walk on the first comparator, so position zero resumes directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q            <= LW'(1);
      m_q            <= LW'(1);
      b_q            <= '0;
      j_q            <= '0;
      flip_q         <= 1'b1;
      sec_q          <= 1'b0;
      k_q            <= '0;
      resume_q       <= '0;
      resume_valid_q <= 1'b1;
    end else begin
      s_q            <= s_d;
      m_q            <= m_d;
      b_q            <= b_d;
      j_q            <= j_d;
      flip_q         <= flip_d;
      sec_q          <= sec_d;
      k_q            <= k_d;
      resume_q       <= resume_d;
      resume_valid_q <= resume_valid_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword_i.op == OP_EMIT) |-> (k_q < step_i))
    else $error("item count ran past the chunk length");

  a_walk_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uword_i.op == OP_EMIT && in_range) |->
      (m_q != '0 && m_q <= s_q && (AW+1)'(j_q) < stage_cnt))
    else $error("walk state is not a valid comparator");

endmodule

@@ rtl/bitonic_sort_index_sequencer_core.sv @@
// Flow: an accepted item passes the capture, multiply and check steps and goes straight to
// the emit step when the chunk continues the previous one or starts past the end, otherwise after a seek.
// The next item is taken only after the program has ended the last one and returned to idle;
// the results of one item come out one per cycle from the emit step while out_stall_i is low.
// Reset: the program counter returns to idle, the walk points at position zero, log_size is 4
// and step_length is 8. There is no clearing pass.
module bitonic_sort_index_sequencer_core
  import bsis_pkg::*;
#(
  parameter int unsigned MAX_LOG_SIZE = 16,
  parameter int unsigned MAX_STEP     = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,

  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,

  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CHW-1:0]  chunk_index_i,

  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IDXW-1:0] element_index_o,
  output logic            past_end_o,
  output logic            last_o
);

  localparam int unsigned SW = $clog2(MAX_STEP + 1);

  logic [LW-1:0]  log_size_q;
  logic [STW-1:0] step_length_q;
  logic           cfg_wr;
  logic [LW-1:0]  n_eff;
  logic [SW-1:0]  step_eff;
  uword_t         uword;
  dp_status_t     status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_size_q    <= LW'(4);
      step_length_q <= STW'(8);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOG_SIZE) begin
        log_size_q <= pwdata[LW-1:0];
      end else begin
        step_length_q <= pwdata[STW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_STEP_LENGTH) ? 32'(step_length_q) : 32'(log_size_q);

  assign n_eff = (log_size_q > LW'(MAX_LOG_SIZE)) ? LW'(MAX_LOG_SIZE) : log_size_q;

  always_comb begin
    priority if (step_length_q == '0) begin
      step_eff = SW'(1);
    end else if (step_length_q > STW'(MAX_STEP)) begin
      step_eff = SW'(MAX_STEP);
    end else begin
      step_eff = SW'(step_length_q);
    end
  end

  assign in_stall_o  = uword.op != OP_CAPTURE;
  assign out_valid_o = uword.op == OP_EMIT;

  bsis_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .uword_o     (uword)
  );

  bsis_datapath #(
    .MAX_LOG_SIZE (MAX_LOG_SIZE),
    .MAX_STEP     (MAX_STEP)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .uword_i         (uword),
    .out_stall_i     (out_stall_i),
    .resume_clr_i    (cfg_wr),
    .n_i             (n_eff),
    .step_i          (step_eff),
    .chunk_index_i   (chunk_index_i),
    .status_o        (status),
    .element_index_o (element_index_o),
    .past_end_o      (past_end_o),
    .last_o          (last_o)
  );

endmodule

@@ dv/bitonic_sort_index_sequencer_core_tb.sv @@
module bitonic_sort_index_sequencer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import bsis_pkg::*;

  localparam int unsigned SLOT_LOG_CAP = 16;
  localparam int unsigned STEP_CAP     = 64;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned STALL_LIMIT  = 4000;

  typedef struct packed {
    logic [IDXW-1:0] slot;
    logic            beyond;
    logic            tail;
  } slot_rec_t;

  logic            clk_i           = 1'b0;
  logic            rst_ni          = 1'b0;
  logic            psel            = 1'b0;
  logic            penable         = 1'b0;
  logic            pwrite          = 1'b0;
  logic [2:0]      paddr           = '0;
  logic [31:0]     pwdata          = '0;
  logic [31:0]     prdata;
  logic            pready;
  logic            in_valid_i      = 1'b0;
  logic            in_stall_o;
  logic [CHW-1:0]  chunk_index_i   = '0;
  logic            out_valid_o;
  logic            out_stall_i     = 1'b0;
  logic [IDXW-1:0] element_index_o;
  logic            past_end_o;
  logic            last_o;

  // Register copies seen by the predictor.
  logic [LW-1:0]   cfg_log  = 5'd4;
  logic [STW-1:0]  cfg_step = 7'd8;

  logic [CHW-1:0]  pending_q[$];
  slot_rec_t       slot_q[$];
  slot_rec_t       exp_rec;

  int unsigned     send_gap   = 0;
  int unsigned     stall_left = 0;
  int unsigned     stall_pick;
  int unsigned     idle_count = 0;
  int unsigned     err_cnt    = 0;
  bit              calm       = 1'b0;

  bitonic_sort_index_sequencer_core #(
    .MAX_LOG_SIZE(SLOT_LOG_CAP),
    .MAX_STEP    (STEP_CAP)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .chunk_index_i  (chunk_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .element_index_o(element_index_o),
    .past_end_o     (past_end_o),
    .last_o         (last_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Length of the full index sequence of a sort over 2^s slots.
  function automatic longint unsigned network_positions(int unsigned s);
    longint unsigned slots;
    slots = 64'd1 << s;
    return slots * s * (s + 1) / 2;
  endfunction

  // Slot touched at position p of the sequence for 2^n slots (p below the end).
  // Descend through the sort halves first, then through the merge recursion.
  function automatic logic [IDXW-1:0] slot_at_position(longint unsigned p, int unsigned n);
    int unsigned     s;
    int unsigned     m;
    longint unsigned q;
    longint unsigned base;
    longint unsigned sub;
    longint unsigned span;
    longint unsigned half;
    bit              flip;
    logic [31:0]     pair;
    logic [31:0]     low;
    logic [31:0]     stage_span;
    logic [31:0]     idx;
    q    = p;
    s    = n;
    base = 0;
    flip = 1'b1;
    while (s > 1) begin
      sub = network_positions(s - 1);
      if (q < sub) begin
        s--;
      end else if (q < 2 * sub) begin
        q    -= sub;
        base += 64'd1 << (s - 1);
        s--;
      end else begin
        q -= 2 * sub;
        break;
      end
    end
    m = s;
    while (m > 1) begin
      span = 64'd1 << m;
      if (q < span) break;
      q   -= span;
      half = (m - 1) * (64'd1 << (m - 1));
      if (q >= half) begin
        q    -= half;
        base += 64'd1 << (m - 1);
      end
      m--;
      flip = 1'b0;
    end
    stage_span = 32'd1 << m;
    pair       = {16'd0, q[16:1]};
    low        = {16'd0, base[15:0]};
    if (!q[0]) begin
      idx = low + pair;
    end else if (flip) begin
      idx = low + stage_span - 32'd1 - pair;
    end else begin
      idx = low + pair + (stage_span >> 1);
    end
    return idx[IDXW-1:0];
  endfunction

  function automatic int unsigned eff_log();
    return (cfg_log > SLOT_LOG_CAP) ? SLOT_LOG_CAP : cfg_log;
  endfunction

  function automatic int unsigned eff_step();
    if (cfg_step == 0) return 1;
    return (cfg_step > STEP_CAP) ? STEP_CAP : cfg_step;
  endfunction

  // Appends one chunk to the driver's backlog.
  function automatic void add_pending(logic [CHW-1:0] chunk);
    pending_q = {pending_q, chunk};
  endfunction

  // Expected slots for one chunk request, appended in emission order.
  function automatic void queue_chunk_slots(logic [CHW-1:0] chunk);
    int unsigned     n;
    int unsigned     step;
    longint unsigned total;
    longint unsigned start;
    longint unsigned pos;
    slot_rec_t       rec;
    n     = eff_log();
    step  = eff_step();
    total = (n == 0) ? 0 : network_positions(n);
    start = longint'(chunk) * step;
    for (int unsigned k = 0; k < step; k++) begin
      pos = start + k;
      if (pos < total) begin
        rec.slot   = slot_at_position(pos, n);
        rec.beyond = 1'b0;
      end else begin
        rec.slot   = '0;
        rec.beyond = 1'b1;
      end
      rec.tail = (k + 1 == step);
      slot_q = {slot_q, rec};
    end
  endfunction

  // Mostly short gaps, a few long ones; none in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        queue_chunk_slots(chunk_index_i);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap != 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_valid_i    <= 1'b1;
          chunk_index_i <= pending_q.pop_front();
          send_gap      <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (slot_q.size() == 0) begin
          $error("unexpected result: element_index %0d past_end %0b last %0b",
                 element_index_o, past_end_o, last_o);
          err_cnt++;
        end else begin
          exp_rec = slot_q.pop_front();
          if (element_index_o !== exp_rec.slot) begin
            $error("element_index: expected %0d, got %0d", exp_rec.slot, element_index_o);
            err_cnt++;
          end
          if (past_end_o !== exp_rec.beyond) begin
            $error("past_end: expected %0b, got %0b", exp_rec.beyond, past_end_o);
            err_cnt++;
          end
          if (last_o !== exp_rec.tail) begin
            $error("last: expected %0b, got %0b", exp_rec.tail, last_o);
            err_cnt++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left  <= stall_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        stall_pick = pick_gap();
        if (stall_pick != 0) begin
          stall_left  <= stall_pick - 1;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
        $display("bitonic_sort_index_sequencer_core_tb: done, errors");
        $finish;
      end else begin
        idle_count <= idle_count + 1;
      end
    end
  end

  task automatic write_reg(logic reg_sel, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_LOG_SIZE) begin
      cfg_log = value[LW-1:0];
    end else begin
      cfg_step = value[STW-1:0];
    end
  endtask

  // Sampled on the falling edge so the clocked blocks have settled.
  task automatic wait_quiet();
    do @(negedge clk_i); while (pending_q.size() != 0 || in_valid_i || slot_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Runs of consecutive chunks continue the walk; other chunks force a restart.
  task automatic fill_chunks(int unsigned count);
    int unsigned     n;
    int unsigned     step;
    int unsigned     pushed;
    int unsigned     run;
    int unsigned     r;
    longint unsigned end_chunk;
    longint unsigned c;
    n         = eff_log();
    step      = eff_step();
    end_chunk = (n == 0) ? 0 : (network_positions(n) + step - 1) / step;
    pushed    = 0;
    while (pushed < count) begin
      r = $urandom_range(0, 9);
      if (r == 9) begin
        // The cursor wraps to zero after the top chunk.
        add_pending('1);
        add_pending('0);
        pushed += 2;
      end else if (r == 8) begin
        add_pending(CHW'($urandom));
        pushed++;
      end else begin
        run = $urandom_range(1, 6);
        if (r == 7 && end_chunk >= 2) begin
          c = end_chunk - 2;
        end else begin
          c = $urandom_range(0, end_chunk[31:0] + 1);
        end
        repeat (run) begin
          add_pending(c[CHW-1:0]);
          c++;
        end
        pushed += run;
      end
    end
  endtask

  task automatic run_phase(logic [31:0] log_v, logic [31:0] step_v, int unsigned count,
                           bit calm_v);
    calm = calm_v;
    write_reg(REG_LOG_SIZE, log_v);
    write_reg(REG_STEP_LENGTH, step_v);
    fill_chunks(count);
    wait_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: walk the whole 16-slot sequence, run past its end, then wrap.
    for (int i = 0; i <= 20; i++) add_pending(CHW'(i));
    add_pending('1);
    add_pending('0);
    wait_quiet();

    run_phase(0, 1, 20, 1'b0);
    run_phase(1, 64, 24, 1'b1);
    run_phase(2, 0, 24, 1'b0);
    run_phase(16, 64, 30, 1'b0);
    run_phase(31, 127, 24, 1'b1);
    run_phase(17, 65, 24, 1'b0);
    run_phase(3, 3, 30, 1'b0);
    run_phase(16, 1, 24, 1'b0);
    for (int i = 0; i < 4; i++) begin
      run_phase($urandom_range(1, 8), $urandom_range(1, 64), 30, i == 2);
    end

    if (err_cnt == 0) begin
      $display("bitonic_sort_index_sequencer_core_tb: done, clean");
    end else begin
      $display("bitonic_sort_index_sequencer_core_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/bsis_pkg.sv
rtl/bsis_sequencer.sv
rtl/bsis_datapath.sv
rtl/bitonic_sort_index_sequencer_core.sv
dv/bitonic_sort_index_sequencer_core_tb.sv
